// File: src/a2fc_pkg.sv
// ---------------------------------------------------------------------------
// a2fc_pkg: shared types and constants for the alignment to flow converter
// Holds the gap character, configuration register indexes, the flow order
// storage size and the sequencer state encoding.
// ---------------------------------------------------------------------------
package a2fc_pkg;

    // Character that marks a gap in either aligned sequence.
    localparam logic [7:0] GAP_CHAR = 8'd45;

    // Number of flow order characters held by the two order registers.
    localparam int ORDER_CHARS = 16;

    // Bits of the running flow index plus key offset fed to the remainder unit.
    localparam int PHASE_SRC_W = 12;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORDER_LOW  = 3'd0;
    localparam logic [2:0] CFG_ORDER_HIGH = 3'd1;
    localparam logic [2:0] CFG_ORDER_LEN  = 3'd2;
    localparam logic [2:0] CFG_KEY_FLOWS  = 3'd3;
    localparam logic [2:0] CFG_WANTED     = 3'd4;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_OPEN  = 6'b000100,
        ST_MOD   = 6'b001000,
        ST_CLOSE = 6'b010000,
        ST_END   = 6'b100000
    } t_state;

endpackage

// File: src/alignment_to_flow_counts.sv
// ---------------------------------------------------------------------------
// alignment_to_flow_counts: aligned columns to flow-space homopolymer counts
// Groups aligned columns into windows of consistent bases and, when a window
// closes, walks the cyclic flow order writing one flow result per cycle unless stalled.
// ---------------------------------------------------------------------------
// A column is evaluated and either extends the open window or closes it and opens a new
// one. Closing a window first finds the flow phase remainder (one bit a cycle through
// a single subtractor), then writes the flows; the last column may close two windows.
// Columns are taken only when idle, and a stalled result word holds up the flow writes.
// Results leave via one register. Reset (synchronous, active low) restores register
// defaults and clears the control state; payload registers are not reset.
module alignment_to_flow_counts
    import a2fc_pkg::*;
#(
    parameter int MAX_ORDER_LENGTH = 16,
    parameter int MAX_FLOWS        = 1024,
    parameter int MAX_COLUMNS      = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Column input: tdata = genome_char[7:0], read_char[15:8]; tlast = last_column.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Result output: tdata = flow_number[9:0], genome_count[17:10],
    // read_count[25:18], columns_used[41:26], zero pad[47:42];
    // tuser = flow_present; tlast = final_result.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int LEN_CAP = (MAX_ORDER_LENGTH < ORDER_CHARS) ? MAX_ORDER_LENGTH : ORDER_CHARS;
    localparam logic [4:0]  LEN_CAP_W = 5'(LEN_CAP);
    localparam logic [12:0] FLOW_CAP  = 13'(MAX_FLOWS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMNS);
    localparam logic [3:0] MOD_STEPS = 4'(PHASE_SRC_W);

    // Low 16 bits of a column count, zero extended where the count is narrower.
    function automatic logic [15:0] to16(input logic [CW-1:0] v);
        logic [CW+15:0] t;
        t = {16'b0, v};
        return t[15:0];
    endfunction

    // Configuration registers.
    logic [63:0] r_order_lo, n_order_lo;
    logic [63:0] r_order_hi, n_order_hi;
    logic [4:0]  r_order_len, n_order_len;
    logic [7:0]  r_key, n_key;
    logic [10:0] r_wanted, n_wanted;

    // Alignment state.
    logic [7:0]    r_gbase, n_gbase, r_rbase, n_rbase;
    logic [7:0]    r_gcnt, n_gcnt, r_rcnt, n_rcnt;
    logic          r_open, n_open;
    logic [10:0]   r_nf, n_nf;
    logic [CW-1:0] r_wsc, n_wsc;
    logic [CW-1:0] r_col, n_col;
    logic          r_fin, n_fin;

    // Sequencer and close loop state.
    t_state      r_state, n_state;
    logic [7:0]  r_g, n_g, r_r, n_r;
    logic        r_last, n_last;
    logic        r_gs, n_gs, r_rs, n_rs, r_hit, n_hit, r_any, n_any;
    logic        r_lastclose, n_lastclose;
    logic [4:0]  r_steps, n_steps;
    logic [4:0]  r_phase, n_phase;
    logic [PHASE_SRC_W-1:0] r_modx, n_modx;
    logic [3:0]  r_modcnt, n_modcnt;

    // Pending flow word, held until it is known whether it is the final one.
    logic        r_pv, n_pv;
    logic [9:0]  r_p_flow, n_p_flow;
    logic [7:0]  r_p_g, n_p_g, r_p_r, n_p_r;

    // Output register.
    logic        r_ov, n_ov;
    logic [9:0]  r_o_flow, n_o_flow;
    logic [7:0]  r_o_g, n_o_g, r_o_r, n_o_r;
    logic        r_o_pres, n_o_pres, r_o_fin, n_o_fin;
    logic [15:0] r_o_used, n_o_used;

    // Derived values.
    logic [4:0]   w_len;
    logic [10:0]  w_lim;
    logic [127:0] w_order;
    logic [7:0]   w_ch;
    logic         w_ext;
    logic         w_equal;
    logic         w_loop;
    logic         w_out_free;
    logic         w_can_push;
    logic [4:0]   w_sh;
    logic [4:0]   w_phase_inc;
    logic         w_gm, w_rm;
    logic [15:0]  w_used;

    // Effective order length and flow limit after clamping.
    always_comb begin
        if (r_order_len == 5'd0) begin
            w_len = 5'd1;
        end else if (r_order_len > LEN_CAP_W) begin
            w_len = LEN_CAP_W;
        end else begin
            w_len = r_order_len;
        end
        w_lim = ({2'b00, r_wanted} > FLOW_CAP) ? FLOW_CAP[10:0] : r_wanted;
    end

    // Current flow character, window consistency and loop condition.
    always_comb begin
        w_order = {r_order_hi, r_order_lo};
        w_ch    = w_order[{r_phase[3:0], 3'b000} +: 8];
        w_ext   = 1'b1;
        if (!(r_g == r_gbase && r_r == r_rbase)) begin
            if (r_g != r_gbase && r_gbase != GAP_CHAR && r_g != GAP_CHAR) begin
                w_ext = 1'b0;
            end
            if (r_r != r_rbase && r_rbase != GAP_CHAR && r_r != GAP_CHAR) begin
                w_ext = 1'b0;
            end
        end
        w_equal = (r_gbase == r_rbase);
        w_loop  = !r_hit && (r_nf < w_lim) && (r_steps < w_len) &&
                  (w_equal || !r_gs || !r_rs);
        w_out_free  = !r_ov || m_axis_tready;
        w_can_push  = !r_pv || w_out_free;
        w_sh        = {r_phase[3:0], r_modx[PHASE_SRC_W-1]};
        w_phase_inc = (5'(r_phase + 5'd1) == w_len) ? 5'd0 : 5'(r_phase + 5'd1);
        w_gm        = (r_gbase == w_ch) || (r_gbase == GAP_CHAR && !r_gs);
        w_rm        = (r_rbase == w_ch) || (r_rbase == GAP_CHAR && !r_rs);
        w_used      = r_fin ? to16(r_wsc) : to16(r_col);
    end

    // Next state of the sequencer, alignment state and output path.
    always_comb begin
        n_order_lo = r_order_lo;  n_order_hi = r_order_hi;
        n_order_len = r_order_len; n_key = r_key; n_wanted = r_wanted;
        n_gbase = r_gbase; n_rbase = r_rbase; n_gcnt = r_gcnt; n_rcnt = r_rcnt;
        n_open = r_open; n_nf = r_nf; n_wsc = r_wsc; n_col = r_col; n_fin = r_fin;
        n_state = r_state; n_g = r_g; n_r = r_r; n_last = r_last;
        n_gs = r_gs; n_rs = r_rs; n_hit = r_hit; n_any = r_any;
        n_lastclose = r_lastclose; n_steps = r_steps; n_phase = r_phase;
        n_modx = r_modx; n_modcnt = r_modcnt;
        n_pv = r_pv; n_p_flow = r_p_flow; n_p_g = r_p_g; n_p_r = r_p_r;
        n_ov = r_ov; n_o_flow = r_o_flow; n_o_g = r_o_g; n_o_r = r_o_r;
        n_o_pres = r_o_pres; n_o_fin = r_o_fin; n_o_used = r_o_used;

        // Output word leaves when the sink takes it.
        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        // Configuration writes.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORDER_LOW:  n_order_lo  = i_cfg_data;
                CFG_ORDER_HIGH: n_order_hi  = i_cfg_data;
                CFG_ORDER_LEN:  n_order_len = i_cfg_data[4:0];
                CFG_KEY_FLOWS:  n_key       = i_cfg_data[7:0];
                CFG_WANTED:     n_wanted    = i_cfg_data[10:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_g     = s_axis_tdata[7:0];
                    n_r     = s_axis_tdata[15:8];
                    n_last  = s_axis_tlast;
                    n_state = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (r_fin) begin
                    n_state = ST_END;
                end else if (r_open && w_ext) begin
                    // Column extends the window.
                    if (r_gbase == GAP_CHAR) n_gbase = r_g;
                    if (r_rbase == GAP_CHAR) n_rbase = r_r;
                    if (r_g != GAP_CHAR && r_gcnt != 8'd255) n_gcnt = 8'(r_gcnt + 8'd1);
                    if (r_r != GAP_CHAR && r_rcnt != 8'd255) n_rcnt = 8'(r_rcnt + 8'd1);
                    if (r_col < COL_MAX) n_col = CW'(r_col + 1'b1);
                    n_lastclose = 1'b1;
                    n_state     = r_last ? ST_MOD : ST_END;
                end else if (r_open) begin
                    n_lastclose = 1'b0;
                    n_state     = ST_MOD;
                end else begin
                    n_state = ST_OPEN;
                end
            end

            ST_OPEN: begin
                if (r_nf >= w_lim) begin
                    n_fin   = 1'b1;
                    n_open  = 1'b0;
                    n_wsc   = r_col;
                    n_state = ST_END;
                end else begin
                    n_open  = 1'b1;
                    n_gbase = r_g;
                    n_rbase = r_r;
                    n_gcnt  = (r_g != GAP_CHAR) ? 8'd1 : 8'd0;
                    n_rcnt  = (r_r != GAP_CHAR) ? 8'd1 : 8'd0;
                    n_wsc   = r_col;
                    if (r_col < COL_MAX) n_col = CW'(r_col + 1'b1);
                    n_lastclose = 1'b1;
                    n_state     = r_last ? ST_MOD : ST_END;
                end
            end

            // Flow phase (key + flow) mod length, one bit a cycle.
            ST_MOD: begin
                n_phase  = (w_sh >= w_len) ? 5'(w_sh - w_len) : w_sh;
                n_modx   = {r_modx[PHASE_SRC_W-2:0], 1'b0};
                n_modcnt = 4'(r_modcnt - 4'd1);
                if (r_modcnt == 4'd1) begin
                    n_state = ST_CLOSE;
                end
            end

            // One flow of the closing window per cycle, while the output can take it.
            ST_CLOSE: begin
                n_open = 1'b0;
                if (w_loop) begin
                    if (w_can_push) begin
                        if (r_pv) begin
                            n_ov = 1'b1; n_o_flow = r_p_flow; n_o_g = r_p_g;
                            n_o_r = r_p_r; n_o_pres = 1'b1; n_o_fin = 1'b0;
                            n_o_used = 16'd0;
                        end
                        n_pv     = 1'b1;
                        n_p_flow = r_nf[9:0];
                        n_p_g    = 8'd0;
                        n_p_r    = 8'd0;
                        if (w_equal) begin
                            if (r_gbase == w_ch) begin
                                n_p_g = r_gcnt;
                                n_p_r = r_rcnt;
                                n_hit = 1'b1;
                            end else begin
                                n_steps = 5'(r_steps + 5'd1);
                            end
                        end else begin
                            if (w_gm) begin
                                n_p_g = r_gcnt;
                                n_gs  = 1'b1;
                            end
                            if (w_rm) begin
                                n_p_r = r_rcnt;
                                n_rs  = 1'b1;
                            end
                            n_steps = 5'(r_steps + 5'd1);
                        end
                        n_nf    = 11'(r_nf + 11'd1);
                        n_phase = w_phase_inc;
                        n_any   = 1'b1;
                    end
                end else begin
                    // Loop done: decide whether emission ends here.
                    if (!r_any) begin
                        n_fin = 1'b1;
                    end else if (!w_equal) begin
                        if (!r_gs || !r_rs || r_nf >= w_lim) begin
                            n_fin = 1'b1;
                            n_wsc = r_col;
                        end
                    end else if (!r_hit) begin
                        n_fin = 1'b1;
                    end else if (r_nf >= w_lim) begin
                        n_fin = 1'b1;
                        n_wsc = r_col;
                    end
                    n_state = (n_fin || r_lastclose) ? ST_END : ST_OPEN;
                end
            end

            // Hand over the held word; on the last column mark the final result.
            ST_END: begin
                if (r_last) begin
                    if (w_out_free) begin
                        n_ov = 1'b1;
                        n_o_fin = 1'b1;
                        n_o_used = w_used;
                        if (r_pv) begin
                            n_o_flow = r_p_flow; n_o_g = r_p_g; n_o_r = r_p_r;
                            n_o_pres = 1'b1;
                        end else begin
                            n_o_flow = 10'd0; n_o_g = 8'd0; n_o_r = 8'd0;
                            n_o_pres = 1'b0;
                        end
                        n_pv = 1'b0;
                        n_gbase = 8'd0; n_rbase = 8'd0; n_gcnt = 8'd0; n_rcnt = 8'd0;
                        n_open = 1'b0; n_nf = 11'd0; n_wsc = '0; n_col = '0;
                        n_fin = 1'b0;
                        n_state = ST_IDLE;
                    end
                end else if (!r_pv) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_ov = 1'b1; n_o_flow = r_p_flow; n_o_g = r_p_g; n_o_r = r_p_r;
                    n_o_pres = 1'b1; n_o_fin = 1'b0; n_o_used = 16'd0;
                    n_pv = 1'b0;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        // Set up a window close: remainder unit inputs and loop flags.
        if (r_state == ST_EVAL || r_state == ST_OPEN) begin
            if (n_state == ST_MOD) begin
                n_open   = 1'b0;
                n_modx   = PHASE_SRC_W'({4'b0000, r_key}) + PHASE_SRC_W'(r_nf);
                n_modcnt = MOD_STEPS;
                n_phase  = 5'd0;
                n_gs = 1'b0; n_rs = 1'b0; n_hit = 1'b0; n_any = 1'b0;
                n_steps = 5'd0;
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_order_lo <= 64'd0; r_order_hi <= 64'd0; r_order_len <= 5'd4;
            r_key <= 8'd0; r_wanted <= 11'd1024;
            r_gbase <= 8'd0; r_rbase <= 8'd0; r_gcnt <= 8'd0; r_rcnt <= 8'd0;
            r_open <= 1'b0; r_nf <= 11'd0; r_wsc <= '0; r_col <= '0; r_fin <= 1'b0;
            r_pv <= 1'b0; r_ov <= 1'b0;
            r_gs <= 1'b0; r_rs <= 1'b0; r_hit <= 1'b0; r_any <= 1'b0;
            r_lastclose <= 1'b0; r_steps <= 5'd0; r_modcnt <= 4'd0;
        end else begin
            r_state <= n_state;
            r_order_lo <= n_order_lo; r_order_hi <= n_order_hi; r_order_len <= n_order_len;
            r_key <= n_key; r_wanted <= n_wanted;
            r_gbase <= n_gbase; r_rbase <= n_rbase; r_gcnt <= n_gcnt; r_rcnt <= n_rcnt;
            r_open <= n_open; r_nf <= n_nf; r_wsc <= n_wsc; r_col <= n_col; r_fin <= n_fin;
            r_pv <= n_pv; r_ov <= n_ov;
            r_gs <= n_gs; r_rs <= n_rs; r_hit <= n_hit; r_any <= n_any;
            r_lastclose <= n_lastclose; r_steps <= n_steps; r_modcnt <= n_modcnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_g <= n_g; r_r <= n_r; r_last <= n_last;
        r_phase <= n_phase; r_modx <= n_modx;
        r_p_flow <= n_p_flow; r_p_g <= n_p_g; r_p_r <= n_p_r;
        r_o_flow <= n_o_flow; r_o_g <= n_o_g; r_o_r <= n_o_r;
        r_o_pres <= n_o_pres; r_o_fin <= n_o_fin; r_o_used <= n_o_used;
    end

    // Ports.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'b000000, r_o_used, r_o_r, r_o_g, r_o_flow};
    assign m_axis_tuser  = r_o_pres;
    assign m_axis_tlast  = r_o_fin;

endmodule

// File: src/a2fc_checker.sv
// ---------------------------------------------------------------------------
// a2fc_checker: port-level checks for the alignment to flow converter
// Watches the result stream and input handshake of the top level.
// ---------------------------------------------------------------------------
module a2fc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // A result without a flow is only the final marker, and carries no counts.
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[25:0] == 26'd0))
        else $error("flowless result is not a clean final marker");

    // Column usage is reported on the final result only, and the pad stays clear.
    a_used_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[47:26] == 22'd0))
        else $error("column count or pad set on a non-final result");

    // The block is ready for a column right after reset.
    a_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after reset");

endmodule

bind alignment_to_flow_counts a2fc_checker u_a2fc_checker (.*);
